// ===== hw/rtl/tmb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmb_pkg
// Shared types and constants of the periodic and timeout timer bank.
// ----------------------------------------------------------------------------
package tmb_pkg;

   localparam int NUM_PERIODS  = 8;
   localparam int NUM_TIMEOUTS = 8;
   localparam int COUNT_WIDTH  = 16;

   localparam int OP_W    = 3;
   localparam int ENTRY_W = 3;
   localparam int VALUE_W = 16;
   localparam int CFG_W   = 4;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   localparam int P_IDX_W   = (NUM_PERIODS > 1) ? $clog2(NUM_PERIODS) : 1;
   localparam int T_IDX_W   = (NUM_TIMEOUTS > 1) ? $clog2(NUM_TIMEOUTS) : 1;
   localparam int SWEEP_LEN = (NUM_PERIODS > NUM_TIMEOUTS) ? NUM_PERIODS : NUM_TIMEOUTS;
   localparam int SWEEP_W   = (SWEEP_LEN > 1) ? $clog2(SWEEP_LEN) : 1;
   localparam int AW        = (SWEEP_W > ENTRY_W) ? SWEEP_W : ENTRY_W;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

   localparam logic REG_PERIODS  = 1'b0;
   localparam logic REG_TIMEOUTS = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_TICK          = 3'd0,
      OP_START_PERIOD  = 3'd1,
      OP_STOP_PERIOD   = 3'd2,
      OP_QUERY_PERIOD  = 3'd3,
      OP_CLEAR_FLAG    = 3'd4,
      OP_START_TIMEOUT = 3'd5,
      OP_STOP_TIMEOUT  = 3'd6,
      OP_QUERY_TIMEOUT = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
   } status_type;

   typedef struct packed {
      logic [CFG_W-1:0] periods_in_use;
      logic [CFG_W-1:0] timeouts_in_use;
   } cfg_type;

endpackage

// ===== hw/rtl/tmb_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmb_csr
// APB-style register port holding the entry counts in use.
// ----------------------------------------------------------------------------
module tmb_csr
   import tmb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   logic [CFG_W-1:0] periods_ff, periods_in;
   logic [CFG_W-1:0] timeouts_ff, timeouts_in;
   logic             wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      periods_in  = periods_ff;
      timeouts_in = timeouts_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_PERIODS:  periods_in  = pwdata[CFG_W-1:0];
            REG_TIMEOUTS: timeouts_in = pwdata[CFG_W-1:0];
            default:      periods_in  = periods_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         periods_ff  <= CFG_RESET;
         timeouts_ff <= CFG_RESET;
      end else begin
         periods_ff  <= periods_in;
         timeouts_ff <= timeouts_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_PERIODS:  prdata = DATA_W'(periods_ff);
         REG_TIMEOUTS: prdata = DATA_W'(timeouts_ff);
         default:      prdata = '0;
      endcase
   end

   assign cfg.periods_in_use  = periods_ff;
   assign cfg.timeouts_in_use = timeouts_ff;

endmodule

// ===== hw/rtl/tmb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmb_ctrl
// Sequencer that runs single-entry operations and the tick sweep.
// ----------------------------------------------------------------------------
module tmb_ctrl
   import tmb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [OP_W-1:0] req_opcode,
   input  status_type      status,
   output cmd_type         cmd,
   output logic            busy
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (op_type'(req_opcode) == OP_TICK) ? ST_SWEEP : ST_EXEC;
            end
         end
         ST_EXEC:  state_in = ST_IDLE;
         ST_SWEEP: begin
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_EXEC:  cmd.exec = 1'b1;
         ST_SWEEP: cmd.step = 1'b1;
         default:  busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/tmb_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmb_datapath
// Timer tables, one-entry update path and result register.
// ----------------------------------------------------------------------------
module tmb_datapath
   import tmb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  cfg_type            cfg,
   input  logic [OP_W-1:0]    req_opcode,
   input  logic [ENTRY_W-1:0] req_entry_index,
   input  logic [VALUE_W-1:0] req_count_value,
   output status_type         status,
   output logic               rsp_strobe,
   output logic               rsp_ok,
   output logic               rsp_flag
);

   logic [COUNT_WIDTH-1:0] p_count_ff  [NUM_PERIODS];
   logic [COUNT_WIDTH-1:0] p_count_in  [NUM_PERIODS];
   logic [COUNT_WIDTH-1:0] p_reload_ff [NUM_PERIODS];
   logic [COUNT_WIDTH-1:0] p_reload_in [NUM_PERIODS];
   logic [NUM_PERIODS-1:0] p_active_ff, p_active_in;
   logic [NUM_PERIODS-1:0] p_done_ff, p_done_in;
   logic [COUNT_WIDTH-1:0] t_count_ff  [NUM_TIMEOUTS];
   logic [COUNT_WIDTH-1:0] t_count_in  [NUM_TIMEOUTS];

   op_type                 op_ff;
   logic [ENTRY_W-1:0]     idx_ff;
   logic [COUNT_WIDTH-1:0] val_ff;
   logic [SWEEP_W-1:0]     ptr_ff, ptr_in;

   logic                   strobe_ff, strobe_in;
   logic                   ok_ff, ok_in;
   logic                   flag_ff, flag_in;

   logic [AW-1:0]          addr;
   logic [P_IDX_W-1:0]     pa;
   logic [T_IDX_W-1:0]     ta;
   logic                   p_hit, t_hit;
   logic [COUNT_WIDTH-1:0] p_dec;

   assign addr  = cmd.step ? AW'(ptr_ff) : AW'(idx_ff);
   assign pa    = addr[P_IDX_W-1:0];
   assign ta    = addr[T_IDX_W-1:0];
   assign p_hit = (32'(addr) < NUM_PERIODS) && (32'(addr) < 32'(cfg.periods_in_use));
   assign t_hit = (32'(addr) < NUM_TIMEOUTS) && (32'(addr) < 32'(cfg.timeouts_in_use));
   assign p_dec = p_count_ff[pa] - COUNT_WIDTH'(1);

   assign status.sweep_last = (ptr_ff == SWEEP_W'(SWEEP_LEN - 1));

   always_comb begin
      p_count_in  = p_count_ff;
      p_reload_in = p_reload_ff;
      p_active_in = p_active_ff;
      p_done_in   = p_done_ff;
      t_count_in  = t_count_ff;
      ptr_in      = ptr_ff;
      strobe_in   = 1'b0;
      ok_in       = ok_ff;
      flag_in     = flag_ff;

      if (cmd.load) begin
         ptr_in = '0;
      end

      if (cmd.step) begin
         ptr_in = ptr_ff + SWEEP_W'(1);
         if (p_hit && p_active_ff[pa]) begin
            if (p_dec == '0) begin
               p_done_in[pa]  = 1'b1;
               p_count_in[pa] = p_reload_ff[pa];
            end else begin
               p_count_in[pa] = p_dec;
            end
         end
         if (t_hit && (t_count_ff[ta] != '0)) begin
            t_count_in[ta] = t_count_ff[ta] - COUNT_WIDTH'(1);
         end
         if (status.sweep_last) begin
            strobe_in = 1'b1;
            ok_in     = 1'b1;
            flag_in   = 1'b0;
         end
      end

      if (cmd.exec) begin
         strobe_in = 1'b1;
         ok_in     = 1'b0;
         flag_in   = 1'b0;
         case (op_ff)
            OP_START_PERIOD: begin
               if (p_hit) begin
                  ok_in           = 1'b1;
                  p_active_in[pa] = 1'b1;
                  p_done_in[pa]   = 1'b0;
                  p_count_in[pa]  = val_ff;
                  p_reload_in[pa] = val_ff;
               end
            end
            OP_STOP_PERIOD: begin
               if (p_hit) begin
                  ok_in           = 1'b1;
                  p_active_in[pa] = 1'b0;
               end
            end
            OP_QUERY_PERIOD: begin
               if (p_hit) begin
                  ok_in   = 1'b1;
                  flag_in = p_done_ff[pa];
               end
            end
            OP_CLEAR_FLAG: begin
               if (p_hit) begin
                  ok_in         = 1'b1;
                  p_done_in[pa] = 1'b0;
               end
            end
            OP_START_TIMEOUT: begin
               if (t_hit) begin
                  ok_in          = 1'b1;
                  t_count_in[ta] = val_ff;
               end
            end
            OP_STOP_TIMEOUT: begin
               if (t_hit) begin
                  ok_in          = 1'b1;
                  t_count_in[ta] = '0;
               end
            end
            OP_QUERY_TIMEOUT: begin
               if (t_hit) begin
                  ok_in   = 1'b1;
                  flag_in = (t_count_ff[ta] == '0);
               end
            end
            default: begin
               ok_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PERIODS; i++) begin
            p_count_ff[i]  <= '0;
            p_reload_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_TIMEOUTS; i++) begin
            t_count_ff[i] <= '0;
         end
         p_active_ff <= '0;
         p_done_ff   <= '0;
         ptr_ff      <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         p_count_ff  <= p_count_in;
         p_reload_ff <= p_reload_in;
         p_active_ff <= p_active_in;
         p_done_ff   <= p_done_in;
         t_count_ff  <= t_count_in;
         ptr_ff      <= ptr_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= op_type'(req_opcode);
         idx_ff <= req_entry_index;
         val_ff <= COUNT_WIDTH'(req_count_value);
      end
      ok_ff   <= ok_in;
      flag_ff <= flag_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_ok     = ok_ff;
   assign rsp_flag   = flag_ff;

endmodule

// ===== hw/rtl/periodic_and_timeout_timer_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_and_timeout_timer_bank
// Bank of periodic timers and one-shot timeouts driven by tick commands.
//
// Channel    Ports                                          Handshake
// request    req_opcode, req_entry_index, req_count_value   start && !busy
// response   rsp_ok, rsp_flag                               rsp_strobe, one cycle
// config     psel, penable, pwrite, paddr, pwdata, prdata   psel && penable && pwrite
//
// A single-entry operation is loaded at acceptance, runs in the EXEC state,
// and then has its result registered. A tick sweeps one entry of each table
// per cycle in the SWEEP state and registers its result after the last entry.
// A new transaction may be accepted in the cycle that carries the result.
// The receiver cannot hold results off, so nothing stalls an accepted transaction.
// Reset is synchronous and clears all timer state and sets both counts to 8.
// ----------------------------------------------------------------------------
module periodic_and_timeout_timer_bank
   import tmb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [OP_W-1:0]    req_opcode,
   input  logic [ENTRY_W-1:0] req_entry_index,
   input  logic [VALUE_W-1:0] req_count_value,
   output logic               rsp_strobe,
   output logic               rsp_ok,
   output logic               rsp_flag,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]  prdata,
   output logic               pready
);

   cmd_type    cmd;
   status_type status;
   cfg_type    cfg;

   tmb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tmb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   tmb_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cfg             (cfg),
      .req_opcode      (req_opcode),
      .req_entry_index (req_entry_index),
      .req_count_value (req_count_value),
      .status          (status),
      .rsp_strobe      (rsp_strobe),
      .rsp_ok          (rsp_ok),
      .rsp_flag        (rsp_flag)
   );

endmodule

// ===== hw/rtl/tmb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmb_checker
// Port-level assertions on command timing and result values.
// ----------------------------------------------------------------------------
module tmb_checker
   import tmb_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [OP_W-1:0]    req_opcode,
   input logic               rsp_strobe,
   input logic               rsp_ok,
   input logic               rsp_flag
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted transaction");

   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while the block is still busy");

   a_entry_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode != OP_TICK)) |-> ##2 rsp_strobe)
      else $error("single-entry transaction result missing");

   a_tick_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode == OP_TICK)) |-> ##(SWEEP_LEN + 1)
      (rsp_strobe && rsp_ok && !rsp_flag))
      else $error("tick transaction result missing or wrong");

   a_flag_needs_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_ok) |-> !rsp_flag)
      else $error("flag set on a rejected transaction");

endmodule

bind periodic_and_timeout_timer_bank tmb_checker u_tmb_checker (.*);
